// ===== hdl/clcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

   // Counter and limit sizing
   localparam int WAIT_COUNTER_BITS = 16;
   localparam int LIMIT_BITS        = 16;
   localparam int CMP_BITS          = (WAIT_COUNTER_BITS > LIMIT_BITS) ?
                                      WAIT_COUNTER_BITS : LIMIT_BITS;

   // Power-on sequence
   localparam int INIT_STEP_COUNT   = 8;
   localparam int INIT_STEP_BITS    = $clog2(INIT_STEP_COUNT + 1);
   localparam int INIT_INDEX_BITS   = $clog2(INIT_STEP_COUNT);
   localparam int INIT_REPEAT_COUNT = 3;   // number of 0x30 wake-up pulses

   typedef logic [WAIT_COUNTER_BITS-1:0] wait_count_type;
   typedef logic [LIMIT_BITS-1:0]        limit_type;
   typedef logic [CMP_BITS-1:0]          cmp_type;
   typedef logic [INIT_STEP_BITS-1:0]    init_step_type;
   typedef logic [7:0]                   byte_type;
   typedef logic [2:0]                   csr_index_type;

   // LCD controller command bytes
   localparam byte_type CMD_FUNCTION_INIT = 8'h30;
   localparam byte_type CMD_FUNCTION_SET  = 8'h38;
   localparam byte_type CMD_DISPLAY_OFF   = 8'h08;
   localparam byte_type CMD_CLEAR         = 8'h01;
   localparam byte_type CMD_HOME          = 8'h02;
   localparam byte_type CMD_ENTRY_MODE    = 8'h06;
   localparam byte_type CMD_DISPLAY_ON    = 8'h0C;
   localparam byte_type CMD_SET_DDRAM     = 8'h80;
   localparam byte_type DDRAM_LINE2       = 8'h40;

   localparam byte_type INIT_BYTES [INIT_STEP_COUNT] = '{
      CMD_FUNCTION_INIT, CMD_FUNCTION_INIT, CMD_FUNCTION_INIT, CMD_FUNCTION_SET,
      CMD_DISPLAY_OFF, CMD_CLEAR, CMD_ENTRY_MODE, CMD_DISPLAY_ON
   };

   // Configuration register indexes
   localparam csr_index_type CSR_ENABLE_TICKS    = 3'd0;
   localparam csr_index_type CSR_SHORT_WAIT      = 3'd1;
   localparam csr_index_type CSR_LONG_WAIT       = 3'd2;
   localparam csr_index_type CSR_POWER_UP_WAIT   = 3'd3;
   localparam csr_index_type CSR_FIRST_INIT_WAIT = 3'd4;
   localparam csr_index_type CSR_LATER_INIT_WAIT = 3'd5;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_COMMAND = 2'd1,
      KIND_DATA    = 2'd2,
      KIND_CURSOR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic [5:0] column;
      logic       line;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable_pin;
      logic [7:0] data_bus;
      logic       busy_res;
      logic       ready_after_init;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic          wr_en;
      csr_index_type index;
      limit_type     data;
   } csr_write_type;

endpackage

`default_nettype wire

// ===== hdl/char_lcd_write_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Write sequencer for an HD44780-style character LCD on an 8-bit bus. Every
// request transfer is either a time tick (kind 0) or a command byte, data byte
// or cursor move; every transfer yields exactly one result carrying the RS, E
// and data-bus pin levels after that item, plus busy, init-done and rejected
// flags. Time advances only on tick items, never on clock cycles, so all the
// csr wait values are in ticks. After reset the block runs the power-on
// sequence by itself and rejects requests until it reports ready_after_init
// and drops busy_res. Rate: one item per clock while req_ready is high; each
// result is registered in the output buffer. The whole state update
// is one pass of logic from the state registers into the result, and a
// two-entry output buffer (main register plus skid) keeps the input side open
// while one result waits; req_ready drops only when both entries are full.
// Write the csr port only while the block is quiet.

module char_lcd_write_sequencer_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire clcd_pkg::req_type       req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      clcd_pkg::rsp_type       rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire clcd_pkg::csr_index_type csr_index,
   input  wire clcd_pkg::limit_type     csr_data
);

   clcd_pkg::csr_write_type csr;
   clcd_pkg::rsp_type       seq_result;
   logic                    push, pop;

   // Output buffer: main register feeds the port, skid catches one more
   clcd_pkg::rsp_type main_ff, main_in, skid_ff, skid_in;
   logic              main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = main_valid_ff && rsp_ready;

   clcd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .item_accept (push),
      .item        (req_data),
      .csr         (csr),
      .result      (seq_result)
   );

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         // advance: skid moves up first, the new result falls in behind it
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = seq_result;
            skid_valid_in = push;
         end else begin
            main_in       = seq_result;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = seq_result;
            main_valid_in = 1'b1;
         end else begin
            // hold the waiting result, park the new one in the skid
            skid_in       = seq_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

`ifndef SYNTHESIS
   // skid never holds a result unless the main register holds an older one
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without main entry");

   // draining a full buffer leaves the skid result in front
   assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && skid_valid_ff && rsp_ready) |=>
      (main_valid_ff && main_ff == $past(skid_ff)))
      else $error("skid result lost on drain");

   // a dropped request is only ever reported while the sequencer is busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rejected) |-> rsp_data.busy_res)
      else $error("rejected result while idle");
`endif

endmodule

`default_nettype wire

// ===== hdl/clcd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clcd_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_accept,
   input  wire clcd_pkg::req_type       item,
   input  wire clcd_pkg::csr_write_type csr,
   output      clcd_pkg::rsp_type       result
);

   typedef enum logic [4:0] {
      PH_POWER = 5'b00001,
      PH_EHIGH = 5'b00010,
      PH_ELOW  = 5'b00100,
      PH_WAIT  = 5'b01000,
      PH_IDLE  = 5'b10000
   } phase_type;

   localparam clcd_pkg::wait_count_type COUNT_TOP = '1;

   // Configuration
   logic [7:0]          enable_ticks_ff;
   clcd_pkg::limit_type short_wait_ff, long_wait_ff, power_up_wait_ff;
   clcd_pkg::limit_type first_init_wait_ff, later_init_wait_ff;

   // Sequencer state
   phase_type                phase_ff, phase_in;
   clcd_pkg::wait_count_type wait_count_ff, wait_count_in;
   clcd_pkg::byte_type       held_byte_ff, held_byte_in;
   logic                     held_rs_ff, held_rs_in;
   clcd_pkg::init_step_type  init_step_ff, init_step_in;
   logic                     init_finished_ff, init_finished_in;

   clcd_pkg::limit_type      limit, post_wait, limit_eff;
   clcd_pkg::wait_count_type count_inc;
   clcd_pkg::init_step_type  step_next;
   logic [6:0]               cursor_addr;
   logic                     done;
   logic                     rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ticks_ff    <= 8'd1;
         short_wait_ff      <= clcd_pkg::limit_type'(50);
         long_wait_ff       <= clcd_pkg::limit_type'(2000);
         power_up_wait_ff   <= clcd_pkg::limit_type'(20000);
         first_init_wait_ff <= clcd_pkg::limit_type'(5000);
         later_init_wait_ff <= clcd_pkg::limit_type'(200);
      end else if (csr.wr_en) begin
         unique case (csr.index)
            clcd_pkg::CSR_ENABLE_TICKS:    enable_ticks_ff    <= csr.data[7:0];
            clcd_pkg::CSR_SHORT_WAIT:      short_wait_ff      <= csr.data;
            clcd_pkg::CSR_LONG_WAIT:       long_wait_ff       <= csr.data;
            clcd_pkg::CSR_POWER_UP_WAIT:   power_up_wait_ff   <= csr.data;
            clcd_pkg::CSR_FIRST_INIT_WAIT: first_init_wait_ff <= csr.data;
            clcd_pkg::CSR_LATER_INIT_WAIT: later_init_wait_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Wait after a write: init pulses first, then clear/home, else short
   always_comb begin
      if (!init_finished_ff && init_step_ff == '0) begin
         post_wait = first_init_wait_ff;
      end else if (!init_finished_ff &&
                   init_step_ff < clcd_pkg::init_step_type'(clcd_pkg::INIT_REPEAT_COUNT)) begin
         post_wait = later_init_wait_ff;
      end else if (!held_rs_ff && (held_byte_ff == clcd_pkg::CMD_CLEAR ||
                                   held_byte_ff == clcd_pkg::CMD_HOME)) begin
         post_wait = long_wait_ff;
      end else begin
         post_wait = short_wait_ff;
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_POWER: limit = power_up_wait_ff;
         PH_EHIGH: limit = clcd_pkg::limit_type'(enable_ticks_ff);
         PH_ELOW:  limit = clcd_pkg::limit_type'(enable_ticks_ff);
         PH_WAIT:  limit = post_wait;
         default:  limit = '0;
      endcase
      // a zero limit counts as one tick
      limit_eff = (limit == '0) ? clcd_pkg::limit_type'(1) : limit;
      count_inc = (wait_count_ff != COUNT_TOP) ? wait_count_ff + 1'b1 : wait_count_ff;
      done      = (clcd_pkg::cmp_type'(count_inc) >= clcd_pkg::cmp_type'(limit_eff)) ||
                  (count_inc == COUNT_TOP);
      step_next = init_step_ff + 1'b1;
      cursor_addr = item.line ?
                    7'(clcd_pkg::DDRAM_LINE2[6:0] + 7'(item.column)) : 7'(item.column);
   end

   always_comb begin
      phase_in         = phase_ff;
      wait_count_in    = wait_count_ff;
      held_byte_in     = held_byte_ff;
      held_rs_in       = held_rs_ff;
      init_step_in     = init_step_ff;
      init_finished_in = init_finished_ff;
      rejected         = 1'b0;

      if (item_accept) begin
         if (item.kind == clcd_pkg::KIND_TICK) begin
            if (phase_ff != PH_IDLE) begin
               wait_count_in = count_inc;
               if (done) begin
                  wait_count_in = '0;
                  unique case (phase_ff)
                     PH_POWER: begin
                        init_step_in = '0;
                        held_byte_in = clcd_pkg::INIT_BYTES[0];
                        held_rs_in   = 1'b0;
                        phase_in     = PH_EHIGH;
                     end
                     PH_EHIGH: phase_in = PH_ELOW;
                     PH_ELOW:  phase_in = PH_WAIT;
                     PH_WAIT: begin
                        if (init_finished_ff) begin
                           phase_in = PH_IDLE;
                        end else if (step_next >=
                                     clcd_pkg::init_step_type'(clcd_pkg::INIT_STEP_COUNT)) begin
                           init_step_in     =
                              clcd_pkg::init_step_type'(clcd_pkg::INIT_STEP_COUNT);
                           init_finished_in = 1'b1;
                           phase_in         = PH_IDLE;
                        end else begin
                           init_step_in = step_next;
                           held_byte_in =
                              clcd_pkg::INIT_BYTES[step_next[clcd_pkg::INIT_INDEX_BITS-1:0]];
                           held_rs_in   = 1'b0;
                           phase_in     = PH_EHIGH;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            wait_count_in = '0;
            phase_in      = PH_EHIGH;
            unique case (item.kind)
               clcd_pkg::KIND_DATA: begin
                  held_byte_in = item.value;
                  held_rs_in   = 1'b1;
               end
               clcd_pkg::KIND_CURSOR: begin
                  held_byte_in = clcd_pkg::CMD_SET_DDRAM | {1'b0, cursor_addr};
                  held_rs_in   = 1'b0;
               end
               default: begin
                  held_byte_in = item.value;
                  held_rs_in   = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_POWER;
         wait_count_ff    <= '0;
         held_byte_ff     <= '0;
         held_rs_ff       <= 1'b0;
         init_step_ff     <= '0;
         init_finished_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         wait_count_ff    <= wait_count_in;
         held_byte_ff     <= held_byte_in;
         held_rs_ff       <= held_rs_in;
         init_step_ff     <= init_step_in;
         init_finished_ff <= init_finished_in;
      end
   end

   always_comb begin
      result.reg_select       = held_rs_in;
      result.enable_pin       = (phase_in == PH_EHIGH);
      result.data_bus         = held_byte_in;
      result.busy_res         = (phase_in != PH_IDLE);
      result.ready_after_init = init_finished_in;
      result.rejected         = rejected;
   end

endmodule

`default_nettype wire
